// ----- rtl/npc_pkg.sv -----
package npc_pkg;

   // Command codes of an input item.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_MAP  = 1'b1;

   // Distance reported when no palette entry is searched.
   localparam logic [17:0] DIST_ALL_ONES = 18'h3FFFF;

   // Reset value of the palette size register.
   localparam logic [8:0] PALETTE_SIZE_RESET = 9'd256;

   typedef struct packed {
      logic       command;
      logic [7:0] entry_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0]  color_index;
      logic [17:0] min_distance;
   } rsp_type;

   // An item as it travels down the chain of search cells.
   typedef struct packed {
      req_type     req;
      logic        found;
      logic [7:0]  best_index;
      logic [17:0] best_distance;
   } stage_type;

endpackage

// ----- rtl/npc_cell.sv -----
module npc_cell
   import npc_pkg::*;
#(
   parameter int unsigned CELL_INDEX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic [8:0] palette_size,
   input  logic      in_valid,
   input  stage_type in_item,
   output logic      out_valid,
   output stage_type out_item
);

   logic [23:0] entry_ff;
   logic [23:0] entry_in;
   logic        a_valid_ff;
   stage_type   a_item_ff;
   logic [17:0] a_dist_ff;
   logic [17:0] a_dist_in;
   logic        b_valid_ff;
   stage_type   b_item_ff;
   stage_type   b_item_in;
   logic [7:0]  diff_r;
   logic [7:0]  diff_g;
   logic [7:0]  diff_b;
   logic        take;

   // A load item writes this cell's entry as it passes, so items keep their order.
   always_comb begin
      entry_in = entry_ff;
      if (advance && in_valid && in_item.req.command == CMD_LOAD
            && in_item.req.entry_index == 8'(CELL_INDEX)) begin
         entry_in = {in_item.req.red, in_item.req.green, in_item.req.blue};
      end
   end

   // First half: squared distance between the pixel and this entry.
   always_comb begin
      diff_r = (in_item.req.red > entry_ff[23:16]) ? in_item.req.red - entry_ff[23:16]
                                                   : entry_ff[23:16] - in_item.req.red;
      diff_g = (in_item.req.green > entry_ff[15:8]) ? in_item.req.green - entry_ff[15:8]
                                                    : entry_ff[15:8] - in_item.req.green;
      diff_b = (in_item.req.blue > entry_ff[7:0]) ? in_item.req.blue - entry_ff[7:0]
                                                  : entry_ff[7:0] - in_item.req.blue;
      a_dist_in = 18'(16'(diff_r * diff_r)) + 18'(16'(diff_g * diff_g))
                + 18'(16'(diff_b * diff_b));
   end

   // Second half: keep the better of the running best and this entry.
   always_comb begin
      take = a_item_ff.req.command == CMD_MAP && 9'(CELL_INDEX) < palette_size
             && (!a_item_ff.found || a_dist_ff < a_item_ff.best_distance);
      b_item_in = a_item_ff;
      if (take) begin
         b_item_in.found         = 1'b1;
         b_item_in.best_index    = 8'(CELL_INDEX);
         b_item_in.best_distance = a_dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
      if (advance) begin
         a_item_ff <= in_item;
         a_dist_ff <= a_dist_in;
         b_item_ff <= b_item_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

// ----- rtl/nearest_palette_color_unit.sv -----
// Channel | Ports              | Direction | Moves
// --------+--------------------+-----------+----------------------------------
// request | req_valid/ready    | in        | one load or map item (req_type)
// result  | rsp_valid/ready    | out       | one result item per map (rsp_type)
// csr     | csr_valid/ready    | in        | palette size, 9 bits
//
// An item enters every cycle while the chain advances; its result is formed by
// the chain of search cells, each with two register stages, that it passes in turn.
// Load items travel the same chain and write their entry on the way.
// Reset clears the valid bits and sets the palette size to 256.
// A result that is not taken holds the whole chain; nothing is lost.
module nearest_palette_color_unit
   import npc_pkg::*;
#(
   parameter int unsigned PALETTE_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [8:0] csr_data
);

   logic [8:0] palette_size_ff;
   logic [8:0] palette_size_in;
   logic       chain_valid [PALETTE_DEPTH + 1];
   stage_type  chain_item [PALETTE_DEPTH + 1];
   logic       advance;

   // Palette size register.
   assign csr_ready = 1'b1;
   always_comb begin
      palette_size_in = palette_size_ff;
      if (csr_valid) begin
         palette_size_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_size_ff <= PALETTE_SIZE_RESET;
      end else begin
         palette_size_ff <= palette_size_in;
      end
   end

   // The chain moves unless a finished result waits to be taken.
   assign advance   = !(rsp_valid && !rsp_ready);
   assign req_ready = advance;

   // Entry to the chain: empty best so far.
   assign chain_valid[0]              = req_valid;
   assign chain_item[0].req           = req_data;
   assign chain_item[0].found         = 1'b0;
   assign chain_item[0].best_index    = 8'd0;
   assign chain_item[0].best_distance = DIST_ALL_ONES;

   for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
      npc_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .palette_size(palette_size_ff),
         .in_valid    (chain_valid[i]),
         .in_item     (chain_item[i]),
         .out_valid   (chain_valid[i + 1]),
         .out_item    (chain_item[i + 1])
      );
   end

   // Load items leave the chain without a result.
   assign rsp_valid = chain_valid[PALETTE_DEPTH]
                      && chain_item[PALETTE_DEPTH].req.command == CMD_MAP;
   assign rsp_data.color_index  = chain_item[PALETTE_DEPTH].best_index;
   assign rsp_data.min_distance = chain_item[PALETTE_DEPTH].best_distance;

endmodule
